// File: rtl/mk_pkg.sv
// Package: shared constants, register indexes and helper functions for the mecanum kinematics unit
package mk_pkg;

  localparam int unsigned QW  = 32;   // Q16.16 word width
  localparam int unsigned FW  = 31;   // unsigned factor width
  localparam int unsigned XW  = 48;   // extended width for sums and shifted products
  localparam int unsigned PW  = 64;   // product width
  localparam int unsigned FRAC = 16;  // fraction bits
  localparam int unsigned LANES = 4;
  localparam int unsigned IDXW = 3;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [FW-1:0] ONE_Q = 31'd65536;

  // Operation codes
  localparam logic OP_INVERSE = 1'b0;
  localparam logic OP_FORWARD = 1'b1;

  // Register indexes
  localparam logic [IDXW-1:0] REG_INV_RADIUS = 3'd0;
  localparam logic [IDXW-1:0] REG_HALF_BASE  = 3'd1;
  localparam logic [IDXW-1:0] REG_MIN_VEL_X  = 3'd2;
  localparam logic [IDXW-1:0] REG_MAX_VEL_X  = 3'd3;
  localparam logic [IDXW-1:0] REG_MIN_VEL_Y  = 3'd4;
  localparam logic [IDXW-1:0] REG_MAX_VEL_Y  = 3'd5;
  localparam logic [IDXW-1:0] REG_MIN_VEL_W  = 3'd6;
  localparam logic [IDXW-1:0] REG_MAX_VEL_W  = 3'd7;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [XW-1:0] qx_t;
  typedef logic signed [PW-1:0] prod_t;

  // Saturate an extended value to the Q16.16 range
  function automatic q_t sat32(input qx_t v);
    q_t r;
    if (v > qx_t'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < qx_t'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // Clamp to [lo, hi]; below lo wins when the limits cross
  function automatic q_t clamp(input q_t v, input q_t lo, input q_t hi);
    q_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Sign-extend a Q16.16 word to the extended width
  function automatic qx_t ext(input q_t v);
    return qx_t'(v);
  endfunction

endpackage

// File: rtl/mecanum_kinematics_unit.sv
// Top level: pipelined four-wheel mecanum inverse and forward kinematics
// Path: a request is registered in stages 1 to 4 in order, then in the output registers.
// Throughput: one request per cycle while out_stall is low; each stage holds one request and a stage
// refills as soon as the stage after it moves, so bubbles close up under stall.
// The depth is set by the two chained multiplies (rotation term, then wheel scale).
// Reset: synchronous, clears all stage valid bits and loads the register defaults.
module mecanum_kinematics_unit #(
  parameter int FK_LINEAR_GAIN   = 16384,
  parameter int FK_ROTATION_GAIN = 32768
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [31:0] goal_w,
  input  logic signed [31:0] meas_front_left,
  input  logic signed [31:0] meas_back_left,
  input  logic signed [31:0] meas_back_right,
  input  logic signed [31:0] meas_front_right,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic signed [31:0] cmd_front_left,
  output logic signed [31:0] cmd_back_left,
  output logic signed [31:0] cmd_back_right,
  output logic signed [31:0] cmd_front_right,
  output logic signed [31:0] body_x,
  output logic signed [31:0] body_y,
  output logic signed [31:0] body_w
);

  localparam logic [mk_pkg::FW-1:0] LIN_GAIN = mk_pkg::FW'(FK_LINEAR_GAIN);
  localparam logic [mk_pkg::FW-1:0] ROT_GAIN = mk_pkg::FW'(FK_ROTATION_GAIN);

  // configuration registers
  logic [mk_pkg::FW-1:0] inv_radius;
  logic [mk_pkg::FW-1:0] half_base;
  mk_pkg::q_t min_vel_x, max_vel_x;
  mk_pkg::q_t min_vel_y, max_vel_y;
  mk_pkg::q_t min_vel_w, max_vel_w;

  // stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // stage 1: clamped goals and forward sums
  logic       s1_op;
  mk_pkg::q_t s1_x, s1_y, s1_w;
  mk_pkg::q_t s1_f0, s1_f1, s1_f2;

  // stage 2: rotation product
  logic          s2_op;
  mk_pkg::q_t    s2_x, s2_y;
  mk_pkg::q_t    s2_f0, s2_f1, s2_f2;
  mk_pkg::prod_t s2_hprod;

  // stage 3: lane operands
  logic                  s3_op;
  mk_pkg::q_t            s3_opa [mk_pkg::LANES];
  logic [mk_pkg::FW-1:0] s3_fac [mk_pkg::LANES];
  logic [mk_pkg::LANES-1:0] s3_neg;

  // stage 4: lane products
  logic                     s4_op;
  mk_pkg::prod_t            s4_prod [mk_pkg::LANES];
  logic [mk_pkg::LANES-1:0] s4_neg;

  // next-value logic
  mk_pkg::q_t            s1_x_next, s1_y_next, s1_w_next;
  mk_pkg::q_t            s1_f0_next, s1_f1_next, s1_f2_next;
  mk_pkg::q_t            h_sat;
  mk_pkg::q_t            s3_opa_next [mk_pkg::LANES];
  logic [mk_pkg::FW-1:0] s3_fac_next [mk_pkg::LANES];
  logic [mk_pkg::LANES-1:0] s3_neg_next;
  mk_pkg::q_t            lane_res [mk_pkg::LANES];

  // handshake: a stage loads when empty or when the stage after it moves
  assign en5 = !v5 || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall  = !en1;
  assign out_valid = v5;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_radius <= mk_pkg::ONE_Q;
      half_base  <= mk_pkg::ONE_Q;
      min_vel_x  <= mk_pkg::Q_MIN;
      max_vel_x  <= mk_pkg::Q_MAX;
      min_vel_y  <= mk_pkg::Q_MIN;
      max_vel_y  <= mk_pkg::Q_MAX;
      min_vel_w  <= mk_pkg::Q_MIN;
      max_vel_w  <= mk_pkg::Q_MAX;
    end else if (wr_en) begin
      case (wr_index)
        mk_pkg::REG_INV_RADIUS: inv_radius <= wr_data[mk_pkg::FW-1:0];
        mk_pkg::REG_HALF_BASE:  half_base  <= wr_data[mk_pkg::FW-1:0];
        mk_pkg::REG_MIN_VEL_X:  min_vel_x  <= wr_data;
        mk_pkg::REG_MAX_VEL_X:  max_vel_x  <= wr_data;
        mk_pkg::REG_MIN_VEL_Y:  min_vel_y  <= wr_data;
        mk_pkg::REG_MAX_VEL_Y:  max_vel_y  <= wr_data;
        mk_pkg::REG_MIN_VEL_W:  min_vel_w  <= wr_data;
        mk_pkg::REG_MAX_VEL_W:  max_vel_w  <= wr_data;
        default: ;
      endcase
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1 logic: clamp goals, form forward wheel sums
  always_comb begin
    s1_x_next  = mk_pkg::clamp(goal_x, min_vel_x, max_vel_x);
    s1_y_next  = mk_pkg::clamp(goal_y, min_vel_y, max_vel_y);
    s1_w_next  = mk_pkg::clamp(goal_w, min_vel_w, max_vel_w);
    s1_f0_next = mk_pkg::sat32(mk_pkg::ext(meas_front_left) + mk_pkg::ext(meas_back_left)
                             + mk_pkg::ext(meas_back_right) + mk_pkg::ext(meas_front_right));
    s1_f1_next = mk_pkg::sat32(mk_pkg::ext(meas_back_right) + mk_pkg::ext(meas_front_right)
                             - mk_pkg::ext(meas_front_left) - mk_pkg::ext(meas_back_left));
    s1_f2_next = mk_pkg::sat32(mk_pkg::ext(meas_back_left) + mk_pkg::ext(meas_front_right)
                             - mk_pkg::ext(meas_front_left) - mk_pkg::ext(meas_back_right));
  end

  // stage 3 logic: rotation term and the four sign patterns, or the forward sums and gains in forward mode
  always_comb begin
    h_sat = mk_pkg::sat32(s2_hprod[mk_pkg::PW-1:mk_pkg::FRAC]);
    s3_opa_next[0] = mk_pkg::sat32(mk_pkg::ext(s2_x) + mk_pkg::ext(s2_y) + mk_pkg::ext(h_sat));
    s3_opa_next[1] = mk_pkg::sat32(mk_pkg::ext(s2_x) - mk_pkg::ext(s2_y) + mk_pkg::ext(h_sat));
    s3_opa_next[2] = mk_pkg::sat32(mk_pkg::ext(s2_x) + mk_pkg::ext(s2_y) - mk_pkg::ext(h_sat));
    s3_opa_next[3] = mk_pkg::sat32(mk_pkg::ext(s2_x) - mk_pkg::ext(s2_y) - mk_pkg::ext(h_sat));
    for (int i = 0; i < mk_pkg::LANES; i++) begin
      s3_fac_next[i] = inv_radius;
    end
    s3_neg_next = 4'b0011;
    if (s2_op == mk_pkg::OP_FORWARD) begin
      s3_opa_next[0] = s2_f0;
      s3_opa_next[1] = s2_f1;
      s3_opa_next[2] = s2_f2;
      s3_opa_next[3] = '0;
      s3_fac_next[0] = LIN_GAIN;
      s3_fac_next[1] = LIN_GAIN;
      s3_fac_next[2] = ROT_GAIN;
      s3_fac_next[3] = '0;
      s3_neg_next    = 4'b0000;
    end
  end

  // stage 5 logic: floor shift, optional negation, saturation
  always_comb begin
    for (int i = 0; i < mk_pkg::LANES; i++) begin
      if (s4_neg[i]) begin
        lane_res[i] = mk_pkg::sat32(-s4_prod[i][mk_pkg::PW-1:mk_pkg::FRAC]);
      end else begin
        lane_res[i] = mk_pkg::sat32(s4_prod[i][mk_pkg::PW-1:mk_pkg::FRAC]);
      end
    end
  end

  // hold or advance the stage payloads
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op <= opcode;
      s1_x  <= s1_x_next;
      s1_y  <= s1_y_next;
      s1_w  <= s1_w_next;
      s1_f0 <= s1_f0_next;
      s1_f1 <= s1_f1_next;
      s1_f2 <= s1_f2_next;
    end
    if (en2) begin
      s2_op    <= s1_op;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_f0    <= s1_f0;
      s2_f1    <= s1_f1;
      s2_f2    <= s1_f2;
      s2_hprod <= $signed({1'b0, half_base}) * s1_w;
    end
    if (en3) begin
      s3_op  <= s2_op;
      s3_neg <= s3_neg_next;
      for (int i = 0; i < mk_pkg::LANES; i++) begin
        s3_opa[i] <= s3_opa_next[i];
        s3_fac[i] <= s3_fac_next[i];
      end
    end
    if (en4) begin
      s4_op  <= s3_op;
      s4_neg <= s3_neg;
      for (int i = 0; i < mk_pkg::LANES; i++) begin
        s4_prod[i] <= s3_opa[i] * $signed({1'b0, s3_fac[i]});
      end
    end
    if (en5) begin
      kind <= s4_op;
      if (s4_op == mk_pkg::OP_FORWARD) begin
        cmd_front_left  <= '0;
        cmd_back_left   <= '0;
        cmd_back_right  <= '0;
        cmd_front_right <= '0;
        body_x          <= lane_res[0];
        body_y          <= lane_res[1];
        body_w          <= lane_res[2];
      end else begin
        cmd_front_left  <= lane_res[0];
        cmd_back_left   <= lane_res[1];
        cmd_back_right  <= lane_res[2];
        cmd_front_right <= lane_res[3];
        body_x          <= '0;
        body_y          <= '0;
        body_w          <= '0;
      end
    end
  end

endmodule
